// ===== sv/ftws_pkg.sv =====
// ----------------------------------------------------------------------------
// ftws_pkg
// Shared types and constants for the frame time window statistics block.
// ----------------------------------------------------------------------------
package ftws_pkg;

    // Field widths
    localparam int TIME_W = 24;
    localparam int FPS_W  = 26;
    localparam int HELD_W = 9;

    // 1000 ms/s scaled by 256 for the time unit and 256 for the fps unit
    localparam logic [FPS_W-1:0] FPS_SCALE = 26'd65536000;

    // Samples per step of the slow count: one more slow sample per hundred
    localparam int  PCT_W    = 7;
    localparam logic [PCT_W-1:0] PCT_LAST = 7'd99;

    // Control sequence of one word
    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_SLOW,
        S_DIVI,
        S_DIVA,
        S_DIVL,
        S_DONE
    } t_state;

endpackage

// ===== sv/frame_time_window_stats.sv =====
// ----------------------------------------------------------------------------
// frame_time_window_stats
// Frame time window: instant fps, average fps and 1% low fps per frame.
// ----------------------------------------------------------------------------
// Each accepted word is one frame time in 1/256 ms. It is written into a ring
// RAM of WINDOW samples, and one result word follows with the instant, average
// and 1% low fps (1/256 fps units) and the sample count. One word is processed
// at a time. The word is taken in the idle cycle. The ring walk then reads one
// RAM entry per cycle, one for each sample held. The slow samples are then
// summed. One shared serial divider then produces the three quotients one
// after another. The next word can be taken in the cycle after the result is
// loaded. A finished result waits in the output register while the next frame
// time is taken. A result that is still waiting when the next one is done holds
// the block in its last step.
// ----------------------------------------------------------------------------
module frame_time_window_stats
    import ftws_pkg::*;
#(
    parameter int WINDOW   = 256,
    parameter int MAX_SLOW = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [TIME_W-1:0] i_frame_time,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [FPS_W-1:0]  o_instant_fps,
    output logic [FPS_W-1:0]  o_average_fps,
    output logic [FPS_W-1:0]  o_low_percent_fps,
    output logic [HELD_W-1:0] o_samples_held
);

    localparam int CW  = $clog2(WINDOW + 1);
    localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW  = TIME_W + CW;
    localparam int NW  = FPS_W + CW;
    localparam int KW  = $clog2(MAX_SLOW + 1);
    localparam int SIW = (MAX_SLOW > 1) ? $clog2(MAX_SLOW) : 1;

    t_state r_state, n_state;

    logic [AW-1:0]     r_wslot;
    logic [CW-1:0]     r_fill;
    logic [CW-1:0]     r_n;
    logic [TIME_W-1:0] r_t;
    logic [CW-1:0]     r_rd_cnt;
    logic              r_rvalid;
    logic [PCT_W-1:0]  r_pct;
    logic [KW-1:0]     r_k;
    logic [KW-1:0]     r_sidx;
    logic [SW-1:0]     r_sum;
    logic [SW-1:0]     r_slow;
    logic [TIME_W-1:0] r_top [MAX_SLOW];
    logic [TIME_W-1:0] n_top [MAX_SLOW];
    logic [MAX_SLOW-1:0] ins_gt;
    logic [FPS_W-1:0]  r_last;
    logic [FPS_W-1:0]  r_avg;
    logic [FPS_W-1:0]  r_low;
    logic              r_out_valid;
    logic [FPS_W-1:0]  r_out_inst;
    logic [FPS_W-1:0]  r_out_avg;
    logic [FPS_W-1:0]  r_out_low;
    logic [HELD_W-1:0] r_out_held;

    logic              accept;
    logic              rd_issue;
    logic              slow_step;
    logic              div_start;
    logic              load_out;
    logic [TIME_W-1:0] rd_data;
    logic [CW-1:0]     fill_next;

    logic              div_busy;
    logic              div_done;
    logic [NW-1:0]     div_num;
    logic [SW-1:0]     div_den;
    logic [NW-1:0]     div_quo;
    logic [FPS_W-1:0]  quo_sat;

    // Sample ring
    ftws_ram #(
        .WIDTH (TIME_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wslot),
        .i_wdata (i_frame_time),
        .i_raddr (r_rd_cnt[AW-1:0]),
        .o_rdata (rd_data)
    );

    // Shared divider
    ftws_div #(
        .NUM_W (NW),
        .DEN_W (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_WALK;
            S_WALK: if (r_rd_cnt == r_n && !r_rvalid) n_state = S_SLOW;
            S_SLOW: if (r_sidx == r_k) n_state = S_DIVI;
            S_DIVI: if (div_done) n_state = S_DIVA;
            S_DIVA: if (div_done) n_state = S_DIVL;
            S_DIVL: if (div_done) n_state = S_DONE;
            S_DONE: if (!r_out_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_ready   = 1'b0;
        rd_issue  = 1'b0;
        slow_step = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_WALK: rd_issue = (r_rd_cnt != r_n);
            S_SLOW: slow_step = (r_sidx != r_k);
            S_DIVI, S_DIVA, S_DIVL: div_start = !div_busy && !div_done;
            S_DONE: load_out = !r_out_valid || i_ready;
            default: o_ready = 1'b0;
        endcase
    end

    assign accept    = i_valid && o_ready;
    assign fill_next = (r_fill == CW'(WINDOW)) ? r_fill : r_fill + 1'b1;

    // Select the divide operands
    always_comb begin
        case (r_state)
            S_DIVA: begin
                div_num = NW'(FPS_SCALE) * NW'(r_n);
                div_den = r_sum;
            end
            S_DIVL: begin
                div_num = NW'(FPS_SCALE) * NW'(r_k);
                div_den = r_slow;
            end
            default: begin
                div_num = NW'(FPS_SCALE);
                div_den = SW'(r_t);
            end
        endcase
    end

    // Clamp the quotient to full scale
    assign quo_sat = (div_quo > NW'(FPS_SCALE)) ? FPS_SCALE : div_quo[FPS_W-1:0];

    // Insert the arriving sample into the descending list of largest samples
    always_comb begin
        for (int p = 0; p < MAX_SLOW; p++) begin
            ins_gt[p] = (rd_data > r_top[p]);
        end
        n_top[0] = ins_gt[0] ? rd_data : r_top[0];
        for (int p = 1; p < MAX_SLOW; p++) begin
            if (!ins_gt[p]) begin
                n_top[p] = r_top[p];
            end else if (!ins_gt[p-1]) begin
                n_top[p] = rd_data;
            end else begin
                n_top[p] = r_top[p-1];
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wslot     <= '0;
            r_fill      <= '0;
            r_rd_cnt    <= '0;
            r_rvalid    <= 1'b0;
            r_sidx      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rvalid <= rd_issue;
            if (accept) begin
                r_wslot  <= (r_wslot == AW'(WINDOW - 1)) ? '0 : r_wslot + 1'b1;
                r_fill   <= fill_next;
                r_rd_cnt <= '0;
                r_sidx   <= '0;
            end
            if (rd_issue) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end
            if (slow_step) begin
                r_sidx <= r_sidx + 1'b1;
            end
            // Hold the last instant value across zero frame times
            if (r_state == S_DIVI && div_done && r_t != '0) begin
                r_last <= div_quo[FPS_W-1:0];
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_t    <= i_frame_time;
            r_n    <= fill_next;
            r_pct  <= '0;
            r_k    <= '0;
            r_sum  <= '0;
            r_slow <= '0;
            for (int p = 0; p < MAX_SLOW; p++) begin
                r_top[p] <= '0;
            end
        end
        // Accumulate the window and track the slow count
        if (r_rvalid) begin
            r_sum <= r_sum + SW'(rd_data);
            r_top <= n_top;
            if (r_pct == '0 && r_k != KW'(MAX_SLOW)) begin
                r_k <= r_k + 1'b1;
            end
            r_pct <= (r_pct == PCT_LAST) ? '0 : r_pct + 1'b1;
        end
        if (slow_step) begin
            r_slow <= r_slow + SW'(r_top[r_sidx[SIW-1:0]]);
        end
        if (div_done && r_state == S_DIVA) begin
            r_avg <= (r_sum == '0) ? '0 : quo_sat;
        end
        if (div_done && r_state == S_DIVL) begin
            r_low <= (r_slow == '0) ? '0 : quo_sat;
        end
        if (load_out) begin
            r_out_inst <= r_last;
            r_out_avg  <= r_avg;
            r_out_low  <= r_low;
            r_out_held <= HELD_W'(r_n);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_instant_fps     = r_out_inst;
    assign o_average_fps     = r_out_avg;
    assign o_low_percent_fps = r_out_low;
    assign o_samples_held    = r_out_held;

endmodule

// ===== sv/ftws_ram.sv =====
// ----------------------------------------------------------------------------
// ftws_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ftws_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ftws_div.sv =====
// ----------------------------------------------------------------------------
// ftws_div
// Restoring divider, one quotient bit per cycle. Quotient is all ones when
// the divisor is zero; the caller masks that case.
// ----------------------------------------------------------------------------
module ftws_div #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;
    logic             fits;

    // Shift in the next numerator bit and trial-subtract
    assign rem_sh   = {r_rem, r_quo[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign fits     = (rem_sh >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_time_window_stats: a scoreboard predicts the
// instant, average and 1% low fps and the sample count for every accepted
// frame time, and each result word is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench
    import ftws_pkg::*;
();

    localparam int WINDOW      = 256;
    localparam int MAX_SLOW    = 3;
    localparam int RANDOM_ITEMS = 450;
    localparam int LONG_HOLD   = 4000;
    localparam longint unsigned CYCLE_LIMIT = 4_000_000;

    typedef struct {
        logic [FPS_W-1:0]  inst;
        logic [FPS_W-1:0]  avg;
        logic [FPS_W-1:0]  low;
        logic [HELD_W-1:0] held;
    } t_frame_stats;

    // Window statistics scoreboard: keeps its own ring and predicts each result
    class fps_scoreboard;
        logic [TIME_W-1:0] ring [WINDOW];
        int unsigned       slot;
        int unsigned       held;
        logic [FPS_W-1:0]  last_inst;
        t_frame_stats      expected_q[$];
        int unsigned       errors;
        int unsigned       frames_noted;
        int unsigned       results_checked;

        function new();
            slot = 0;
            held = 0;
            last_inst = '0;
            errors = 0;
            frames_noted = 0;
            results_checked = 0;
        endfunction

        // Rate from a sample count over a summed time, clipped to the scale
        function logic [FPS_W-1:0] fps_ratio(longint unsigned cnt, longint unsigned total);
            longint unsigned q;
            if (total == 0)
                return '0;
            q = 64'(FPS_SCALE) * cnt / total;
            if (q > 64'(FPS_SCALE))
                q = 64'(FPS_SCALE);
            return q[FPS_W-1:0];
        endfunction

        // Store one accepted frame time and queue the stats it must produce
        function void note_frame(logic [TIME_W-1:0] ft);
            t_frame_stats      stats;
            longint unsigned   total;
            longint unsigned   slow_total;
            logic [TIME_W-1:0] top [MAX_SLOW];
            logic [TIME_W-1:0] v;
            logic [TIME_W-1:0] tmp;
            int unsigned       slow_n;
            int unsigned       idx;
            int unsigned       i;
            int unsigned       j;

            if (ft != 0)
                last_inst = FPS_SCALE / ft;
            ring[slot] = ft;
            slot = (slot + 1) % WINDOW;
            if (held < WINDOW)
                held++;

            slow_n = (held + 99) / 100;
            if (slow_n < 1)
                slow_n = 1;
            if (slow_n > MAX_SLOW)
                slow_n = MAX_SLOW;

            // walk the held samples, keeping the slowest ones in descending order
            for (j = 0; j < MAX_SLOW; j++)
                top[j] = '0;
            total = 0;
            for (i = 0; i < held; i++) begin
                idx = (slot + WINDOW - held + i) % WINDOW;
                v = ring[idx];
                total += v;
                for (j = 0; j < slow_n; j++) begin
                    if (v > top[j]) begin
                        tmp = top[j];
                        top[j] = v;
                        v = tmp;
                    end
                end
            end
            slow_total = 0;
            for (j = 0; j < slow_n; j++)
                slow_total += top[j];

            stats.inst = last_inst;
            stats.avg  = fps_ratio(held, total);
            stats.low  = fps_ratio(slow_n, slow_total);
            stats.held = held[HELD_W-1:0];
            expected_q.push_back(stats);
            frames_noted++;
        endfunction

        function void compare_field(string name, longint unsigned want, logic [FPS_W-1:0] got);
            if (got !== want[FPS_W-1:0]) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one result word with the oldest pending prediction
        function void check_result(t_frame_stats got);
            t_frame_stats want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no frame pending, actual %0d/%0d/%0d/%0d",
                         $time, got.inst, got.avg, got.low, got.held);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("instant_fps", want.inst, got.inst);
            compare_field("average_fps", want.avg, got.avg);
            compare_field("low_percent_fps", want.low, got.low);
            compare_field("samples_held", want.held, FPS_W'(got.held));
            results_checked++;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [TIME_W-1:0] i_frame_time = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [FPS_W-1:0]  o_instant_fps;
    logic [FPS_W-1:0]  o_average_fps;
    logic [FPS_W-1:0]  o_low_percent_fps;
    logic [HELD_W-1:0] o_samples_held;

    fps_scoreboard     sb;
    logic [TIME_W-1:0] frame_plan[$];
    t_frame_stats      seen;

    frame_time_window_stats #(
        .WINDOW   (WINDOW),
        .MAX_SLOW (MAX_SLOW)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_frame_time      (i_frame_time),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_instant_fps     (o_instant_fps),
        .o_average_fps     (o_average_fps),
        .o_low_percent_fps (o_low_percent_fps),
        .o_samples_held    (o_samples_held)
    );

    always #5 i_clk = ~i_clk;

    // Random frame time: mostly plausible render times, with spikes and extremes
    function automatic logic [TIME_W-1:0] pick_frame_time();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 58)
            return TIME_W'($urandom_range(1000, 20000));
        else if (r < 68)
            return TIME_W'($urandom_range(20000, 400000));
        else if (r < 78)
            return TIME_W'($urandom());
        else if (r < 84)
            return TIME_W'($urandom_range(0, 3));
        else if (r < 88)
            return '0;
        else if (r < 92)
            return {TIME_W{1'b1}};
        else
            return TIME_W'(1) << $urandom_range(0, TIME_W - 1);
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic offer_frame(input logic [TIME_W-1:0] ft);
        i_valid <= 1'b1;
        i_frame_time <= ft;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_frame(ft);
    endtask

    // Send the whole plan in bursts with random gaps between them
    task automatic run_sender();
        int unsigned pos;
        int unsigned burst;
        int unsigned gap;
        int unsigned r;
        pos = 0;
        while (pos < frame_plan.size()) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && pos < frame_plan.size()) begin
                offer_frame(frame_plan[pos]);
                pos++;
                burst--;
            end
            r = $urandom_range(0, 9);
            if (r < 4)
                gap = 0;
            else if (r < 8)
                gap = $urandom_range(1, 20);
            else if (r < 9)
                gap = $urandom_range(20, 120);
            else
                gap = $urandom_range(100, 450);
            if (gap > 0) begin
                i_valid <= 1'b0;
                i_frame_time <= TIME_W'($urandom());
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    // Receiver: quiet runs, short stalls, longer stalls, and one long hold-off
    initial begin : receiver
        int unsigned stall_left;
        int unsigned run_left;
        int unsigned r;
        bit          long_done;
        stall_left = 0;
        run_left = 0;
        long_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_done && sb != null && sb.results_checked >= 120) begin
                long_done = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    r = $urandom_range(0, 9);
                    if (r < 3) begin
                        run_left = $urandom_range(50, 400);
                    end else if (r < 8) begin
                        stall_left = $urandom_range(1, 12);
                        run_left = $urandom_range(0, 6);
                    end else if (r < 9) begin
                        stall_left = $urandom_range(30, 150);
                    end else begin
                        stall_left = $urandom_range(200, 700);
                    end
                end
            end
        end
    end

    // Check every result word taken by the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen.inst = o_instant_fps;
            seen.avg  = o_average_fps;
            seen.low  = o_low_percent_fps;
            seen.held = o_samples_held;
            sb.check_result(seen);
        end
    end

    initial begin : limit
        #(CYCLE_LIMIT * 10);
        $display("Timeout with %0d frames still pending", sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : main
        int unsigned k;
        sb = new();

        // zeros from reset, saturation, extremes and bit patterns first
        frame_plan = '{24'd0, 24'd0, 24'd1, 24'd0, 24'd2, 24'hFFFFFF, 24'hFFFFFE,
                       24'hAAAAAA, 24'h555555, 24'd0, 24'd4267, 24'd4266, 24'd1,
                       24'h800000, 24'd3, 24'd65535, 24'd16384, 24'd0, 24'd1000};
        for (k = 0; k < RANDOM_ITEMS; k++)
            frame_plan.push_back(pick_frame_time());

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_sender();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (500) @(posedge i_clk);

        $display("Sent %0d frame times, checked %0d results, ring wrapped %0d times.",
                 sb.frames_noted, sb.results_checked, sb.frames_noted / WINDOW);
        $display("Included zero frames, saturated rates, full-range times and a %0d-cycle hold.",
                 LONG_HOLD);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d errors, %0d frames without result", sb.errors, sb.pending());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ftws_pkg.sv
sv/ftws_ram.sv
sv/ftws_div.sv
sv/frame_time_window_stats.sv
test/testbench.sv
